FILE: rtl/lru_key_value_cache_defines.svh
// Assertion macros for the LRU key/value cache.
// Included by the top level; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define LKV_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define LKV_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define LKV_ASSERT(label, clock, reset, prop, msg)
`define LKV_ASSERT_ALWAYS(label, clock, prop, msg)
`endif

`endif

FILE: rtl/lru_kvc_pkg.sv
// Shared constants, operation codes and request/response structs for the
// LRU key/value cache. No dependencies.
`default_nettype none

package lru_kvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int CTR_W       = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int RANK_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int FUNC_W      = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET   = 2'd0,
    FUNC_PUT   = 2'd1,
    FUNC_PROBE = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef struct packed {
    logic               fire;
    func_t              func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/lru_kvc_store.sv
// Entry store of the LRU key/value cache: tags, values, valid bits, recency
// ranks and the fill count, with the combinational lookup and registered update.
// Depends on lru_kvc_pkg.
`default_nettype none

module lru_kvc_store
  import lru_kvc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CAP_W-1:0] capacity,
  input  wire req_t             req,
  output rsp_t                  rsp
);

  logic [KEY_W-1:0]   keys   [MAX_ENTRIES];
  logic [VALUE_W-1:0] values [MAX_ENTRIES];
  logic [RANK_W-1:0]  rank   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   count;

  logic [RANK_W-1:0]  rank_next [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_next;
  logic [CNT_W-1:0]   count_next;

  logic [MAX_ENTRIES-1:0] match;
  logic                   hit_any;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       victim_idx;
  logic [IDX_W-1:0]       ins_idx;
  logic [CNT_W-1:0]       eff_cap;
  logic                   full;
  logic [RANK_W-1:0]      hit_rank;
  logic                   do_write;
  logic [IDX_W-1:0]       wr_idx;

  // Parallel tag compare and lowest-index picks.
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == req.key);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
      // Ranks of valid entries are a permutation of 0..count-1.
      if (valid[i] && ({1'b0, rank[i]} == (count - CNT_W'(1)))) begin
        victim_idx = IDX_W'(i);
      end
    end
    hit_any  = |match;
    hit_rank = rank[hit_idx];
  end

  // Clamp capacity to 1..MAX_ENTRIES.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(capacity) > CNT_W'(MAX_ENTRIES)) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign full    = count >= eff_cap;
  assign ins_idx = full ? victim_idx : free_idx;

  always_comb begin
    valid_next = valid;
    count_next = count;
    do_write   = 1'b0;
    wr_idx     = hit_idx;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_next[i] = rank[i];
    end
    if (req.fire) begin
      case (req.func)
        FUNC_GET, FUNC_PUT: begin
          if (hit_any) begin
            // Refresh: entries more recent than the hit move down one.
            do_write = (req.func == FUNC_PUT);
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (valid[i] && (IDX_W'(i) != hit_idx) && (rank[i] < hit_rank)) begin
                rank_next[i] = rank[i] + RANK_W'(1);
              end
            end
            rank_next[hit_idx] = '0;
          end else if (req.func == FUNC_PUT) begin
            // Insert as most recent, replacing the oldest entry when full.
            do_write = 1'b1;
            wr_idx   = ins_idx;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (valid[i] && (IDX_W'(i) != ins_idx)) begin
                rank_next[i] = rank[i] + RANK_W'(1);
              end
            end
            rank_next[ins_idx]  = '0;
            valid_next[ins_idx] = 1'b1;
            if (!full) begin
              count_next = count + CNT_W'(1);
            end
          end
        end
        FUNC_PROBE: begin
        end
        FUNC_CLEAR: begin
          valid_next = '0;
          count_next = '0;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_next[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      count <= count_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  // Tag and value storage: no reset, never read while invalid.
  always_ff @(posedge clk) begin
    if (do_write) begin
      keys[wr_idx]   <= req.key;
      values[wr_idx] <= req.value;
    end
  end

  always_comb begin
    rsp.hit         = hit_any && (req.func != FUNC_CLEAR);
    rsp.read_value  = (hit_any && (req.func == FUNC_GET)) ? values[hit_idx] : '0;
    rsp.entry_count = count_next;
  end

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: stream ports, input and result
// registers, get statistics. Depends on lru_kvc_pkg, lru_kvc_store and
// lru_key_value_cache_defines.svh.
`default_nettype none
`include "lru_key_value_cache_defines.svh"

// Fully associative 16-entry key/value cache with least-recently-used
// replacement. Each input transfer carries an operation in tuser (get, put,
// probe, clear) and a key and value in tdata; each one yields exactly one
// result transfer with the hit flag in tuser and, in tdata, the read value,
// the entry count after the operation and the wrapping get/hit/miss
// counters. A request lands in an input register, then the tag compare and
// recency-rank update over all sixteen entries write the entry store and
// the result register together. The block takes one request per cycle;
// each result is valid once held in the result register. The only thing that
// slows it is backpressure on the result side, which holds the result
// register and in turn the input register. capacity (1..16, zero reads as
// 1, larger values as 16) may be written only while idle; lowering it below
// the current count drops nothing at once. Clear empties the entries and
// keeps the counters. There is no clearing pass after reset.
module lru_key_value_cache
  import lru_kvc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration: capacity
  input  wire logic                 cfg_we,
  input  wire logic [CAP_W-1:0]     cfg_wdata,
  // requests
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [63:0]          s_axis_tdata,   // key[31:0], value[63:32]
  input  wire logic [FUNC_W-1:0]    s_axis_tuser,   // func[1:0]
  // results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [135:0]              m_axis_tdata,   // read_value[31:0],
                                                    // entry_count[36:32],
                                                    // access_count[68:37],
                                                    // hit_count[100:69],
                                                    // miss_count[132:101], zero pad
  output logic [0:0]                m_axis_tuser    // hit[0]
);

  localparam int M_FIELDS_W = VALUE_W + CNT_W + 3 * CTR_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  // Capacity register.
  logic [CAP_W-1:0] capacity;

  // Input register.
  logic               in_valid;
  func_t              in_func;
  logic [KEY_W-1:0]   in_key;
  logic [VALUE_W-1:0] in_value;

  // Result register.
  logic               out_valid;
  logic               out_hit;
  logic [VALUE_W-1:0] out_read_value;
  logic [CNT_W-1:0]   out_entry_count;
  logic [CTR_W-1:0]   out_access;
  logic [CTR_W-1:0]   out_hits;
  logic [CTR_W-1:0]   out_misses;

  // Get statistics.
  logic [CTR_W-1:0] access_cnt;
  logic [CTR_W-1:0] hit_cnt;
  logic [CTR_W-1:0] miss_cnt;
  logic [CTR_W-1:0] access_cnt_next;
  logic [CTR_W-1:0] hit_cnt_next;
  logic [CTR_W-1:0] miss_cnt_next;

  logic advance;
  req_t req;
  rsp_t rsp;

  // Move the input item into the result register whenever that slot is free
  // or is being drained this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Input register: load on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func  <= func_t'(s_axis_tuser);
      in_key   <= s_axis_tdata[KEY_W-1:0];
      in_value <= s_axis_tdata[KEY_W +: VALUE_W];
    end
  end

  always_comb begin
    req.fire  = advance;
    req.func  = in_func;
    req.key   = in_key;
    req.value = in_value;
  end

  lru_kvc_store u_store (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .req      (req),
    .rsp      (rsp)
  );

  // Count gets; the result carries the counters after this operation.
  always_comb begin
    access_cnt_next = access_cnt;
    hit_cnt_next    = hit_cnt;
    miss_cnt_next   = miss_cnt;
    if (advance && (in_func == FUNC_GET)) begin
      access_cnt_next = access_cnt + CTR_W'(1);
      if (rsp.hit) begin
        hit_cnt_next = hit_cnt + CTR_W'(1);
      end else begin
        miss_cnt_next = miss_cnt + CTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_cnt <= '0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
    end else begin
      access_cnt <= access_cnt_next;
      hit_cnt    <= hit_cnt_next;
      miss_cnt   <= miss_cnt_next;
    end
  end

  // Result register: hold while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit         <= rsp.hit;
      out_read_value  <= rsp.read_value;
      out_entry_count <= rsp.entry_count;
      out_access      <= access_cnt_next;
      out_hits        <= hit_cnt_next;
      out_misses      <= miss_cnt_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_hit;
  assign m_axis_tdata  = {(M_DATA_W - M_FIELDS_W)'(0), out_misses, out_hits, out_access,
                          out_entry_count, out_read_value};

  // Every get is counted exactly once as a hit or a miss.
  `LKV_ASSERT(a_counts_balance, clk, rst,
    out_valid |-> ((out_hits + out_misses) == out_access),
    "hit and miss counts do not add up to the access count")

  // A miss never returns data.
  `LKV_ASSERT(a_miss_zero, clk, rst,
    (out_valid && !out_hit) |-> (out_read_value == '0),
    "nonzero read value without a hit")

  // Clear leaves an empty cache and reports no hit.
  `LKV_ASSERT(a_clear_empties, clk, rst,
    (advance && (in_func == FUNC_CLEAR)) |=> (out_valid && !out_hit && (out_entry_count == '0)),
    "clear did not empty the cache")

  // After a put the cache holds at least one entry and never more than MAX_ENTRIES.
  `LKV_ASSERT(a_put_count, clk, rst,
    (advance && (in_func == FUNC_PUT))
      |=> ((out_entry_count != '0) && (out_entry_count <= CNT_W'(MAX_ENTRIES))),
    "entry count out of range after put")

endmodule

`default_nettype wire
